// File: src/pafp_pkg.sv
// package: shared types, constants and codes of the partition allocator
package pafp_pkg;

	localparam int MAX_PARTS_DEF = 32;
	localparam int ADDR_W = 16;
	localparam logic [ADDR_W-1:0] RESET_SPLIT = 16'd10;
	localparam logic [ADDR_W-1:0] RESET_CAP = 16'd1024;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOFIT = 3'd1;
	localparam logic [2:0] ST_BADSIZE = 3'd2;
	localparam logic [2:0] ST_BADINDEX = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_SPLIT = 2'd1;
	localparam logic [1:0] REG_CAP = 2'd2;

	localparam logic [1:0] POL_BEST = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [15:0] request_size;
		logic [4:0]  partition_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] granted_address;
		logic [4:0]  granted_index;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_PREV, S_PREV_MERGE,
		S_NEXT, S_NEXT_MERGE, S_DONE, S_OUT
	} state_t;

	typedef enum logic [1:0] {ADDR_SCAN, ADDR_CUR, ADDR_PREV, ADDR_NEXT} addr_sel_t;
	typedef enum logic [1:0] {RES_NONE, RES_PICK, RES_CUR} res_src_t;

	typedef struct packed {
		logic       load;
		logic       scan;
		logic       clr_busy;
		logic       set_busy_pick;
		logic       insert;
		logic       merge;
		logic       merge_prev;
		logic       save_a;
		logic       res_load;
		logic [2:0] res_code;
		res_src_t   res_src;
		addr_sel_t  addr_sel;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_size;
		logic bad_index;
		logic scan_last;
		logic found;
		logic whole;
		logic full;
		logic cur_zero;
		logic next_exists;
		logic rd_busy;
	} sts_t;

endpackage

// File: src/pafp_ctrl.sv
// controller: sequences scan, split and merge steps of one transaction
module pafp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	input  pafp_pkg::sts_t  sts,
	output pafp_pkg::cmd_t  cmd
);

	pafp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pafp_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pafp_pkg::S_IDLE: if (req_valid) state_d = pafp_pkg::S_CHECK;
			pafp_pkg::S_CHECK: begin
				if (sts.is_free) state_d = sts.bad_index ? pafp_pkg::S_OUT : pafp_pkg::S_PREV;
				else state_d = sts.zero_size ? pafp_pkg::S_OUT : pafp_pkg::S_SCAN;
			end
			pafp_pkg::S_SCAN: if (sts.scan_last) state_d = pafp_pkg::S_DECIDE;
			pafp_pkg::S_DECIDE: state_d = pafp_pkg::S_OUT;
			pafp_pkg::S_PREV: begin
				if (!sts.cur_zero && !sts.rd_busy) state_d = pafp_pkg::S_PREV_MERGE;
				else state_d = pafp_pkg::S_NEXT;
			end
			pafp_pkg::S_PREV_MERGE: state_d = pafp_pkg::S_NEXT;
			pafp_pkg::S_NEXT: begin
				if (sts.next_exists && !sts.rd_busy) state_d = pafp_pkg::S_NEXT_MERGE;
				else state_d = pafp_pkg::S_DONE;
			end
			pafp_pkg::S_NEXT_MERGE: state_d = pafp_pkg::S_DONE;
			pafp_pkg::S_DONE: state_d = pafp_pkg::S_OUT;
			pafp_pkg::S_OUT: if (rsp_ready) state_d = pafp_pkg::S_IDLE;
			default: state_d = pafp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.addr_sel = pafp_pkg::ADDR_CUR;
		cmd.res_src = pafp_pkg::RES_NONE;
		cmd.res_code = pafp_pkg::ST_OK;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			pafp_pkg::S_IDLE: begin
				req_ready = 1'b1;
				cmd.load = req_valid;
			end
			pafp_pkg::S_CHECK: begin
				if (sts.is_free) begin
					if (sts.bad_index) begin
						cmd.res_load = 1'b1;
						cmd.res_code = pafp_pkg::ST_BADINDEX;
					end else begin
						cmd.clr_busy = 1'b1;
					end
				end else if (sts.zero_size) begin
					cmd.res_load = 1'b1;
					cmd.res_code = pafp_pkg::ST_BADSIZE;
				end
			end
			pafp_pkg::S_SCAN: begin
				cmd.addr_sel = pafp_pkg::ADDR_SCAN;
				cmd.scan = 1'b1;
			end
			pafp_pkg::S_DECIDE: begin
				cmd.res_load = 1'b1;
				if (!sts.found) begin
					cmd.res_code = pafp_pkg::ST_NOFIT;
				end else if (sts.whole) begin
					cmd.set_busy_pick = 1'b1;
					cmd.res_src = pafp_pkg::RES_PICK;
				end else if (sts.full) begin
					cmd.res_code = pafp_pkg::ST_FULL;
				end else begin
					cmd.insert = 1'b1;
					cmd.res_src = pafp_pkg::RES_PICK;
				end
			end
			pafp_pkg::S_PREV: begin
				cmd.addr_sel = pafp_pkg::ADDR_PREV;
				cmd.save_a = !sts.cur_zero && !sts.rd_busy;
			end
			pafp_pkg::S_PREV_MERGE: begin
				cmd.merge = 1'b1;
				cmd.merge_prev = 1'b1;
			end
			pafp_pkg::S_NEXT: begin
				cmd.addr_sel = pafp_pkg::ADDR_NEXT;
				cmd.save_a = sts.next_exists && !sts.rd_busy;
			end
			pafp_pkg::S_NEXT_MERGE: cmd.merge = 1'b1;
			pafp_pkg::S_DONE: begin
				cmd.res_load = 1'b1;
				cmd.res_src = pafp_pkg::RES_CUR;
			end
			pafp_pkg::S_OUT: rsp_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

// File: src/pafp_datapath.sv
// datapath: partition table, configuration registers, fit search and result register
module pafp_datapath #(
	parameter int MAX_PARTITIONS = pafp_pkg::MAX_PARTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [1:0]                 cfg_index,
	input  logic [pafp_pkg::ADDR_W-1:0] cfg_data,
	input  pafp_pkg::req_t             req,
	input  pafp_pkg::cmd_t             cmd,
	output pafp_pkg::sts_t             sts,
	output pafp_pkg::rsp_t             rsp
);

	localparam int AW = pafp_pkg::ADDR_W;
	localparam int IW = $clog2(MAX_PARTITIONS);
	localparam int CW = $clog2(MAX_PARTITIONS + 1);

	logic [AW-1:0] base_q [MAX_PARTITIONS];
	logic [AW-1:0] len_q [MAX_PARTITIONS];
	logic          busy_q [MAX_PARTITIONS];
	logic [CW-1:0] count_q;

	logic [1:0]    policy_q;
	logic [AW-1:0] limit_q;

	logic          op_q;
	logic [AW-1:0] size_q;
	logic [4:0]    idx_q;
	logic [IW-1:0] scan_q, pick_q, cur_q;
	logic          found_q;
	logic [AW-1:0] pick_base_q, pick_len_q, a_q;
	pafp_pkg::rsp_t rsp_q;

	logic [IW-1:0] rd_addr, ins_k, merge_t;
	logic [AW-1:0] rd_base, rd_len, left, sum;
	logic          rd_busy, eligible, better;

	always_comb begin
		unique case (cmd.addr_sel)
			pafp_pkg::ADDR_SCAN: rd_addr = scan_q;
			pafp_pkg::ADDR_CUR:  rd_addr = cur_q;
			pafp_pkg::ADDR_PREV: rd_addr = cur_q - IW'(1);
			pafp_pkg::ADDR_NEXT: rd_addr = cur_q + IW'(1);
			default:             rd_addr = cur_q;
		endcase
	end

	assign rd_base = base_q[rd_addr];
	assign rd_len = len_q[rd_addr];
	assign rd_busy = busy_q[rd_addr];
	assign left = pick_len_q - size_q;
	assign sum = a_q + rd_len;
	assign ins_k = pick_q + IW'(1);
	assign merge_t = cmd.merge_prev ? cur_q - IW'(1) : cur_q;

	assign eligible = !rd_busy && (rd_len >= size_q);
	assign better = !found_q
		|| (policy_q == pafp_pkg::POL_BEST && rd_len < pick_len_q)
		|| (policy_q == pafp_pkg::POL_WORST && rd_len > pick_len_q);

	always_comb begin
		sts.is_free = (op_q == pafp_pkg::OP_FREE);
		sts.zero_size = (size_q == '0);
		sts.bad_index = (32'(idx_q) >= 32'(count_q));
		sts.scan_last = (32'(scan_q) + 1 >= 32'(count_q));
		sts.found = found_q;
		sts.whole = (left <= limit_q);
		sts.full = (32'(count_q) >= MAX_PARTITIONS);
		sts.cur_zero = (cur_q == '0);
		sts.next_exists = (32'(cur_q) + 1 < 32'(count_q));
		sts.rd_busy = rd_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			limit_q <= pafp_pkg::RESET_SPLIT;
		end else if (cfg_valid) begin
			if (cfg_index == pafp_pkg::REG_POLICY) policy_q <= cfg_data[1:0];
			if (cfg_index == pafp_pkg::REG_SPLIT) limit_q <= cfg_data;
		end
	end

	// partition table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PARTITIONS; j++) begin
				base_q[j] <= '0;
				len_q[j] <= (j == 0) ? pafp_pkg::RESET_CAP : '0;
				busy_q[j] <= 1'b0;
			end
			count_q <= CW'(1);
		end else if (cfg_valid && cfg_index == pafp_pkg::REG_CAP) begin
			for (int j = 0; j < MAX_PARTITIONS; j++) busy_q[j] <= 1'b0;
			base_q[0] <= '0;
			len_q[0] <= cfg_data;
			count_q <= CW'(1);
		end else begin
			if (cmd.clr_busy) busy_q[cur_q] <= 1'b0;
			if (cmd.set_busy_pick) busy_q[pick_q] <= 1'b1;
			if (cmd.insert) begin
				for (int j = 1; j < MAX_PARTITIONS; j++) begin
					if (32'(j) > 32'(ins_k)) begin
						base_q[j] <= base_q[j-1];
						len_q[j] <= len_q[j-1];
						busy_q[j] <= busy_q[j-1];
					end
				end
				base_q[ins_k] <= pick_base_q + size_q;
				len_q[ins_k] <= left;
				busy_q[ins_k] <= 1'b0;
				len_q[pick_q] <= size_q;
				busy_q[pick_q] <= 1'b1;
				count_q <= count_q + CW'(1);
			end
			if (cmd.merge) begin
				for (int j = 0; j < MAX_PARTITIONS - 1; j++) begin
					if (32'(j) > 32'(merge_t)) begin
						base_q[j] <= base_q[j+1];
						len_q[j] <= len_q[j+1];
						busy_q[j] <= busy_q[j+1];
					end
				end
				len_q[merge_t] <= sum;
				count_q <= count_q - CW'(1);
			end
		end
	end

	// transaction and search registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			found_q <= 1'b0;
			cur_q <= '0;
			pick_q <= '0;
			pick_base_q <= '0;
			pick_len_q <= '0;
		end else begin
			if (cmd.load) begin
				scan_q <= '0;
				found_q <= 1'b0;
				cur_q <= IW'(req.partition_index);
			end
			if (cmd.scan) begin
				scan_q <= scan_q + IW'(1);
				if (eligible && better) begin
					found_q <= 1'b1;
					pick_q <= scan_q;
					pick_base_q <= rd_base;
					pick_len_q <= rd_len;
				end
			end
			if (cmd.merge && cmd.merge_prev) cur_q <= cur_q - IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.operation;
			size_q <= req.request_size;
			idx_q <= req.partition_index;
		end
		if (cmd.save_a) a_q <= rd_len;
		if (cmd.res_load) begin
			rsp_q.status <= cmd.res_code;
			unique case (cmd.res_src)
				pafp_pkg::RES_PICK: begin
					rsp_q.granted_address <= pick_base_q;
					rsp_q.granted_index <= 5'(pick_q);
				end
				pafp_pkg::RES_CUR: begin
					rsp_q.granted_address <= rd_base;
					rsp_q.granted_index <= 5'(cur_q);
				end
				default: begin
					rsp_q.granted_address <= '0;
					rsp_q.granted_index <= '0;
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

// File: src/partition_allocator_fit_policy.sv
// top level: variable partition allocator with first, best and worst fit
//
// Requests arrive on req (req_valid/req_ready) as allocate or free
// transactions; each gives exactly one response on rsp (rsp_valid/rsp_ready)
// with a status, a granted base address and a table index.
// Configuration writes use cfg_valid/cfg_ready with cfg_index (0 fit
// policy, 1 split limit, 2 capacity) and cfg_data; cfg_ready is always
// high, and a capacity write reloads the table with one free partition.
// One transaction is in flight at a time. An allocate scans the table
// entries, one entry per cycle, before it answers. A free does its
// neighbour reads and merges one per cycle. A zero size or a bad index
// is answered from the check, with no scan or merge. A split or merge
// shifts all later table entries together.
// After reset the table holds one free partition of length 1024, the fit
// policy is first fit and the split limit is 10. A stalled rsp holds its
// value and req_ready stays low until the response is taken.
module partition_allocator_fit_policy #(
	parameter int MAX_PARTITIONS = pafp_pkg::MAX_PARTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  pafp_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output pafp_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [pafp_pkg::ADDR_W-1:0] cfg_data
);

	pafp_pkg::cmd_t cmd;
	pafp_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	pafp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pafp_datapath #(.MAX_PARTITIONS(MAX_PARTITIONS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !rsp_valid) else $error("request taken while response pending");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= pafp_pkg::ST_FULL) else $error("bad status code");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != pafp_pkg::ST_OK |->
		rsp.granted_address == '0 && rsp.granted_index == '0)
		else $error("error response carries nonzero fields");
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready && !rsp_valid)
		else $error("accepted request not held in progress");
`endif

endmodule

// File: tb/sv/tb_partition_allocator_fit_policy.sv
// testbench: partition allocator checked against a behavioural table predictor
`timescale 1ns / 1ps

module tb_partition_allocator_fit_policy;

	localparam int NPART = pafp_pkg::MAX_PARTS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	pafp_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	pafp_pkg::rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = pafp_pkg::REG_POLICY;
	logic [15:0] cfg_data = '0;

	partition_allocator_fit_policy uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [1:0] pol;
	logic [15:0] split_lim;
	logic [15:0] cap;
	logic [15:0] pbase [NPART];
	logic [15:0] plen [NPART];
	logic pbusy [NPART];
	int pcount;

	pafp_pkg::rsp_t grant_queue[$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	int n_ok = 0;
	int n_full = 0;
	bit idle_on = 1'b1;

	function automatic void table_reload();
		for (int i = 0; i < NPART; i++) begin
			pbase[i] = '0;
			plen[i] = '0;
			pbusy[i] = 1'b0;
		end
		plen[0] = cap;
		pcount = 1;
	endfunction

	function automatic void drop_entry(int k);
		for (int j = k; j + 1 < pcount; j++) begin
			pbase[j] = pbase[j+1];
			plen[j] = plen[j+1];
			pbusy[j] = pbusy[j+1];
		end
		pcount--;
	endfunction

	function automatic pafp_pkg::rsp_t predict_grant(pafp_pkg::req_t r);
		pafp_pkg::rsp_t o;
		int pick;
		int p;
		logic [15:0] left;
		o = '0;
		pick = -1;
		if (r.operation == pafp_pkg::OP_ALLOC) begin
			if (r.request_size == 0) begin
				o.status = pafp_pkg::ST_BADSIZE;
				return o;
			end
			for (int i = 0; i < pcount; i++) begin
				if (pbusy[i] || plen[i] < r.request_size) continue;
				if (pick < 0) pick = i;
				else if (pol == pafp_pkg::POL_BEST && plen[i] < plen[pick]) pick = i;
				else if (pol == pafp_pkg::POL_WORST && plen[i] > plen[pick]) pick = i;
			end
			if (pick < 0) begin
				o.status = pafp_pkg::ST_NOFIT;
				return o;
			end
			left = plen[pick] - r.request_size;
			if (left > split_lim) begin
				if (pcount >= NPART) begin
					o.status = pafp_pkg::ST_FULL;
					return o;
				end
				for (int j = pcount; j > pick + 1; j--) begin
					pbase[j] = pbase[j-1];
					plen[j] = plen[j-1];
					pbusy[j] = pbusy[j-1];
				end
				pbase[pick+1] = pbase[pick] + r.request_size;
				plen[pick+1] = left;
				pbusy[pick+1] = 1'b0;
				plen[pick] = r.request_size;
				pcount++;
			end
			pbusy[pick] = 1'b1;
			o.status = pafp_pkg::ST_OK;
			o.granted_address = pbase[pick];
			o.granted_index = pick[4:0];
			return o;
		end
		p = int'(r.partition_index);
		if (p >= pcount) begin
			o.status = pafp_pkg::ST_BADINDEX;
			return o;
		end
		pbusy[p] = 1'b0;
		if (p > 0 && !pbusy[p-1]) begin
			plen[p-1] = plen[p-1] + plen[p];
			drop_entry(p);
			p--;
		end
		if (p + 1 < pcount && !pbusy[p+1]) begin
			plen[p] = plen[p] + plen[p+1];
			drop_entry(p + 1);
		end
		o.status = pafp_pkg::ST_OK;
		o.granted_address = pbase[p];
		o.granted_index = p[4:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// response side
	always @(posedge clk) begin
		pafp_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			n_got++;
			if (grant_queue.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = grant_queue.pop_front();
				if (rsp.status != want.status)
					report_mismatch("status", int'(rsp.status), int'(want.status));
				if (rsp.granted_address != want.granted_address)
					report_mismatch("address", int'(rsp.granted_address),
						int'(want.granted_address));
				if (rsp.granted_index != want.granted_index)
					report_mismatch("index", int'(rsp.granted_index),
						int'(want.granted_index));
				if (want.status == pafp_pkg::ST_OK) n_ok++;
				if (want.status == pafp_pkg::ST_FULL) n_full++;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ready <= idle_on ? ($urandom_range(99) >= 15) : 1'b1;
	end

	task automatic send(pafp_pkg::req_t r);
		@(negedge clk);
		if (idle_on)
			while ($urandom_range(99) < 15) @(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		grant_queue.push_back(predict_grant(r));
		n_sent++;
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic send_checked(pafp_pkg::req_t r, pafp_pkg::rsp_t want);
		pafp_pkg::rsp_t seen;
		seen = predict_grant(r);
		if (seen != want) report_mismatch("directed prediction", int'(seen), int'(want));
		@(negedge clk);
		if (idle_on)
			while ($urandom_range(99) < 15) @(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		grant_queue.push_back(want);
		n_sent++;
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic drain();
		while (grant_queue.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pafp_pkg::REG_POLICY: pol = val[1:0];
			pafp_pkg::REG_SPLIT: split_lim = val;
			pafp_pkg::REG_CAP: begin
				cap = val;
				table_reload();
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic pafp_pkg::req_t mk(logic op, logic [15:0] sz, logic [4:0] ix);
		pafp_pkg::req_t r;
		r.operation = op;
		r.request_size = sz;
		r.partition_index = ix;
		return r;
	endfunction

	function automatic pafp_pkg::rsp_t rs(logic [2:0] st, logic [15:0] a, logic [4:0] ix);
		pafp_pkg::rsp_t o;
		o.status = st;
		o.granted_address = a;
		o.granted_index = ix;
		return o;
	endfunction

	typedef struct {
		pafp_pkg::req_t r;
		bit typed;
		pafp_pkg::rsp_t want;
	} row_t;

	row_t dir_rows [$];

	function automatic pafp_pkg::req_t rand_req();
		pafp_pkg::req_t r;
		int k;
		k = $urandom_range(99);
		r = '0;
		r.request_size = 16'($urandom);
		r.partition_index = 5'($urandom);
		if (k < 55) begin
			r.operation = pafp_pkg::OP_ALLOC;
			case ($urandom_range(3))
				0: r.request_size = 16'($urandom_range(1, 16));
				1: r.request_size = 16'($urandom_range(1, 120));
				2: r.request_size = 16'($urandom_range(1, cap > 0 ? cap : 1));
				default: r.request_size = 16'($urandom);
			endcase
			if ($urandom_range(49) == 0) r.request_size = '0;
		end else begin
			r.operation = pafp_pkg::OP_FREE;
			if (k < 95 && pcount > 0) r.partition_index = 5'($urandom_range(pcount - 1));
		end
		return r;
	endfunction

	initial begin
		pol = 2'd0;
		split_lim = pafp_pkg::RESET_SPLIT;
		cap = pafp_pkg::RESET_CAP;
		table_reload();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed
		dir_rows.push_back('{mk(pafp_pkg::OP_ALLOC, 16'd0, 5'd0), 1'b1,
			rs(pafp_pkg::ST_BADSIZE, 16'd0, 5'd0)});
		dir_rows.push_back('{mk(pafp_pkg::OP_FREE, 16'hffff, 5'd31), 1'b1,
			rs(pafp_pkg::ST_BADINDEX, 16'd0, 5'd0)});
		dir_rows.push_back('{mk(pafp_pkg::OP_ALLOC, 16'hffff, 5'd31), 1'b1,
			rs(pafp_pkg::ST_NOFIT, 16'd0, 5'd0)});
		dir_rows.push_back('{mk(pafp_pkg::OP_ALLOC, 16'd100, 5'd0), 1'b1,
			rs(pafp_pkg::ST_OK, 16'd0, 5'd0)});
		dir_rows.push_back('{mk(pafp_pkg::OP_ALLOC, 16'd200, 5'd0), 1'b1,
			rs(pafp_pkg::ST_OK, 16'd100, 5'd1)});
		dir_rows.push_back('{mk(pafp_pkg::OP_ALLOC, 16'd50, 5'd0), 1'b1,
			rs(pafp_pkg::ST_OK, 16'd300, 5'd2)});
		dir_rows.push_back('{mk(pafp_pkg::OP_FREE, 16'd0, 5'd1), 1'b0, '0});
		dir_rows.push_back('{mk(pafp_pkg::OP_FREE, 16'd0, 5'd1), 1'b0, '0});
		dir_rows.push_back('{mk(pafp_pkg::OP_FREE, 16'd0, 5'd0), 1'b0, '0});
		dir_rows.push_back('{mk(pafp_pkg::OP_ALLOC, 16'd670, 5'd0), 1'b0, '0});
		dir_rows.push_back('{mk(pafp_pkg::OP_FREE, 16'd0, 5'd2), 1'b0, '0});
		dir_rows.push_back('{mk(pafp_pkg::OP_FREE, 16'd0, 5'd0), 1'b0, '0});
		foreach (dir_rows[i]) begin
			if (dir_rows[i].typed) send_checked(dir_rows[i].r, dir_rows[i].want);
			else send(dir_rows[i].r);
		end

		// table full: small split limit, many tiny allocations
		write_reg(pafp_pkg::REG_SPLIT, 16'd0);
		write_reg(pafp_pkg::REG_CAP, 16'd100);
		for (int i = 0; i < 34; i++) send(mk(pafp_pkg::OP_ALLOC, 16'd1, 5'd0));
		send(mk(pafp_pkg::OP_ALLOC, 16'd69, 5'd0));
		write_reg(pafp_pkg::REG_CAP, 16'd0);
		send(mk(pafp_pkg::OP_ALLOC, 16'd1, 5'd0));
		send(mk(pafp_pkg::OP_FREE, 16'd0, 5'd0));

		// random phases through the policies and extremes
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(pafp_pkg::REG_POLICY, ph[1:0]);
			case (ph % 4)
				0: write_reg(pafp_pkg::REG_SPLIT, 16'd0);
				1: write_reg(pafp_pkg::REG_SPLIT, 16'hffff);
				2: write_reg(pafp_pkg::REG_SPLIT, pafp_pkg::RESET_SPLIT);
				default: write_reg(pafp_pkg::REG_SPLIT, 16'($urandom_range(64)));
			endcase
			case (ph % 3)
				0: write_reg(pafp_pkg::REG_CAP, 16'hffff);
				1: write_reg(pafp_pkg::REG_CAP, 16'd1);
				default: write_reg(pafp_pkg::REG_CAP, 16'($urandom_range(200, 4000)));
			endcase
			idle_on = (ph != 5);
			for (int i = 0; i < 150; i++) begin
				send(rand_req());
				if (ph == 7 && i == 75) drain();
			end
		end
		idle_on = 1'b1;

		drain();
		$display("sent %0d requests, %0d responses, %0d ok, %0d table-full",
			n_sent, n_got, n_ok, n_full);
		$display("covered all fit policies, split limit and capacity extremes");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
